// File: src/dlp_pkg.sv
// Shared types, constants and the character classifier for the decimal list parser.
`timescale 1ns / 1ps

package dlp_pkg;

   // Sizing of the parser
   localparam int LIST_LENGTH    = 3;
   localparam int MESSAGE_LENGTH = 50;
   localparam int DIGIT_LIMIT    = 9;
   localparam int QUEUE_DEPTH    = 2;

   localparam int BYTE_W   = 8;
   localparam int SCORE_W  = 30;
   localparam int COUNT_W  = 2;
   localparam int OUT_RANKS = 3;
   localparam int CHAR_W   = $clog2(MESSAGE_LENGTH);
   localparam int DIGIT_W  = $clog2(DIGIT_LIMIT + 2);
   localparam int STAGE_W  = $clog2(LIST_LENGTH + 1);
   localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int PROD_W   = SCORE_W + 4;

   localparam logic [SCORE_W-1:0] NUMBER_CEILING = SCORE_W'((10 ** DIGIT_LIMIT) - 1);
   localparam logic [CHAR_W-1:0]  CHAR_LIMIT     = CHAR_W'(MESSAGE_LENGTH - 1);
   localparam logic [DIGIT_W-1:0] DIGIT_FULL     = DIGIT_W'(DIGIT_LIMIT);
   localparam logic [DIGIT_W-1:0] DIGIT_OVER     = DIGIT_W'(DIGIT_LIMIT + 1);

   // Characters the parser reacts to
   localparam logic [BYTE_W-1:0] CH_TERM   = 8'h5E;  // '^'
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;  // '9'
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;  // ' '
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;  // ','
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;  // '['
   localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;  // ']'

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_DIGIT = 2'd1,
      CLS_SEP   = 2'd2,
      CLS_TERM  = 2'd3
   } char_class_type;

   // One classified character as it travels from front to back
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
   } char_item_type;

   function automatic char_item_type classify(input logic [BYTE_W-1:0] ch);
      char_item_type item;
      logic [BYTE_W-1:0] offset;
      offset     = ch - CH_ZERO;
      item.digit = offset[3:0];
      if (ch == CH_TERM) begin
         item.cls = CLS_TERM;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         item.cls = CLS_DIGIT;
      end else if (ch == CH_SPACE || ch == CH_COMMA || ch == CH_LBRACK || ch == CH_RBRACK) begin
         item.cls = CLS_SEP;
      end else begin
         item.cls = CLS_OTHER;
      end
      return item;
   endfunction

endpackage

// File: src/dlp_front.sv
// Front stage: accepts raw bytes and registers their character class.
`timescale 1ns / 1ps

module dlp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dlp_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       cls_valid,
   input  logic                       cls_stall,
   output dlp_pkg::char_item_type     cls_item
);

   logic                   valid_ff, valid_in;
   dlp_pkg::char_item_type item_ff, item_in;
   logic                   accept;

   // Stage holds one item; it refills as soon as the queue takes the current one
   assign req_stall = valid_ff && cls_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = dlp_pkg::classify(req_rx_byte);
      end else if (!cls_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign cls_valid = valid_ff;
   assign cls_item  = item_ff;

endmodule

// File: src/dlp_queue.sv
// Short FIFO of classified items between the front and back stages.
`timescale 1ns / 1ps

module dlp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   output logic                   wr_stall,
   input  dlp_pkg::char_item_type wr_item,
   output logic                   rd_valid,
   input  logic                   rd_stall,
   output dlp_pkg::char_item_type rd_item
);

   dlp_pkg::char_item_type            slots_ff [dlp_pkg::QUEUE_DEPTH];
   logic [dlp_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [dlp_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [dlp_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              push, pop;

   localparam logic [dlp_pkg::QPTR_W-1:0] LAST_SLOT = dlp_pkg::QPTR_W'(dlp_pkg::QUEUE_DEPTH - 1);
   localparam logic [dlp_pkg::QCNT_W-1:0] FULL      = dlp_pkg::QCNT_W'(dlp_pkg::QUEUE_DEPTH);

   assign wr_stall = (count_ff == FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_item  = slots_ff[rd_ptr_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_valid && !rd_stall;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: src/dlp_back.sv
// Back stage: number accumulation, staging, publishing and the result register.
`timescale 1ns / 1ps

module dlp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cls_valid,
   output logic                        cls_stall,
   input  dlp_pkg::char_item_type      cls_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dlp_pkg::SCORE_W-1:0] rsp_score_first,
   output logic [dlp_pkg::SCORE_W-1:0] rsp_score_second,
   output logic [dlp_pkg::SCORE_W-1:0] rsp_score_third,
   output logic [dlp_pkg::COUNT_W-1:0] rsp_new_count
);

   logic [dlp_pkg::CHAR_W-1:0]  char_count_ff, char_count_in;
   logic [dlp_pkg::SCORE_W-1:0] digit_value_ff, digit_value_in;
   logic [dlp_pkg::DIGIT_W-1:0] digit_count_ff, digit_count_in;
   logic [dlp_pkg::STAGE_W-1:0] staged_count_ff, staged_count_in;
   logic [dlp_pkg::SCORE_W-1:0] staged_ff [dlp_pkg::LIST_LENGTH];
   logic [dlp_pkg::SCORE_W-1:0] staged_in [dlp_pkg::LIST_LENGTH];
   logic [dlp_pkg::SCORE_W-1:0] published_ff [dlp_pkg::LIST_LENGTH];
   logic [dlp_pkg::SCORE_W-1:0] published_in [dlp_pkg::LIST_LENGTH];

   logic                        out_valid_ff, out_valid_in;
   logic [dlp_pkg::SCORE_W-1:0] out_score_ff [dlp_pkg::OUT_RANKS];
   logic [dlp_pkg::SCORE_W-1:0] out_score_in [dlp_pkg::OUT_RANKS];
   logic [dlp_pkg::COUNT_W-1:0] out_count_ff, out_count_in;

   // Pending number committed into the staging list
   logic [dlp_pkg::SCORE_W-1:0] commit_scores [dlp_pkg::LIST_LENGTH];
   logic [dlp_pkg::STAGE_W-1:0] commit_count;
   logic [dlp_pkg::PROD_W-1:0]  times_ten;
   logic [dlp_pkg::SCORE_W-1:0] next_digit_value;
   logic                        take;

   assign cls_stall = out_valid_ff && rsp_stall;
   assign take      = cls_valid && !cls_stall;

   always_comb begin
      commit_count = staged_count_ff;
      for (int i = 0; i < dlp_pkg::LIST_LENGTH; i++) begin
         commit_scores[i] = staged_ff[i];
      end
      if (digit_count_ff != '0 &&
          staged_count_ff < dlp_pkg::STAGE_W'(dlp_pkg::LIST_LENGTH)) begin
         for (int i = 0; i < dlp_pkg::LIST_LENGTH; i++) begin
            if (staged_count_ff == dlp_pkg::STAGE_W'(i)) begin
               commit_scores[i] = digit_value_ff;
            end
         end
         commit_count = staged_count_ff + 1'b1;
      end
   end

   // value * 10 + digit, clamped to the ceiling
   always_comb begin
      times_ten = ({4'b0, digit_value_ff} << 3) + ({4'b0, digit_value_ff} << 1)
                  + dlp_pkg::PROD_W'(cls_item.digit);
      if (times_ten > dlp_pkg::PROD_W'(dlp_pkg::NUMBER_CEILING)) begin
         next_digit_value = dlp_pkg::NUMBER_CEILING;
      end else begin
         next_digit_value = times_ten[dlp_pkg::SCORE_W-1:0];
      end
   end

   // Message state update
   always_comb begin
      char_count_in   = char_count_ff;
      digit_value_in  = digit_value_ff;
      digit_count_in  = digit_count_ff;
      staged_count_in = staged_count_ff;
      staged_in       = staged_ff;
      published_in    = published_ff;
      out_valid_in    = out_valid_ff && rsp_stall;
      out_score_in    = out_score_ff;
      out_count_in    = out_count_ff;

      if (take) begin
         if (cls_item.cls == dlp_pkg::CLS_TERM) begin
            for (int i = 0; i < dlp_pkg::LIST_LENGTH; i++) begin
               if (dlp_pkg::STAGE_W'(i) < commit_count) begin
                  published_in[i] = commit_scores[i];
               end
            end
            for (int i = 0; i < dlp_pkg::OUT_RANKS; i++) begin
               out_score_in[i] = '0;
               if (i < dlp_pkg::LIST_LENGTH) begin
                  out_score_in[i] = published_in[i];
               end
            end
            out_count_in    = dlp_pkg::COUNT_W'(commit_count);
            out_valid_in    = 1'b1;
            char_count_in   = '0;
            digit_value_in  = '0;
            digit_count_in  = '0;
            staged_count_in = '0;
         end else if (char_count_ff >= dlp_pkg::CHAR_LIMIT) begin
            // Overlong message is thrown away
            char_count_in   = '0;
            digit_value_in  = '0;
            digit_count_in  = '0;
            staged_count_in = '0;
         end else begin
            char_count_in = char_count_ff + 1'b1;
            unique case (cls_item.cls)
               dlp_pkg::CLS_DIGIT: begin
                  if (digit_count_ff >= dlp_pkg::DIGIT_FULL) begin
                     digit_value_in = dlp_pkg::NUMBER_CEILING;
                     digit_count_in = dlp_pkg::DIGIT_OVER;
                  end else begin
                     digit_value_in = next_digit_value;
                     digit_count_in = digit_count_ff + 1'b1;
                  end
               end
               dlp_pkg::CLS_SEP: begin
                  staged_in       = commit_scores;
                  staged_count_in = commit_count;
                  digit_value_in  = '0;
                  digit_count_in  = '0;
               end
               default: begin
                  // other characters only count toward the message length
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff   <= '0;
         digit_value_ff  <= '0;
         digit_count_ff  <= '0;
         staged_count_ff <= '0;
         out_valid_ff    <= 1'b0;
         for (int i = 0; i < dlp_pkg::LIST_LENGTH; i++) begin
            published_ff[i] <= '0;
         end
      end else begin
         char_count_ff   <= char_count_in;
         digit_value_ff  <= digit_value_in;
         digit_count_ff  <= digit_count_in;
         staged_count_ff <= staged_count_in;
         out_valid_ff    <= out_valid_in;
         published_ff    <= published_in;
      end
      staged_ff    <= staged_in;
      out_score_ff <= out_score_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_score_first  = out_score_ff[0];
   assign rsp_score_second = out_score_ff[1];
   assign rsp_score_third  = out_score_ff[2];
   assign rsp_new_count    = out_count_ff;

endmodule

// File: src/decimal_list_parser_top.sv
// Top level of the ASCII decimal list parser.
//
// Usage: received bytes enter on the req_ channel (req_valid, req_stall,
// req_rx_byte), one item per accepted byte. Digits build a number, a space,
// comma or bracket commits it, and '^' ends the message. Each '^' yields one
// item on the rsp_ channel: the three published scores after the first
// numbers of the message replaced the leading ones, and new_count telling
// how many were replaced. Other bytes yield nothing. A message that grows
// past 49 bytes before its '^' is dropped; numbers saturate at 999999999.
// A result appears on rsp_valid once its '^' has passed the front register and a
// queue slot; the result register loads as it leaves the queue.
// Throughput: one byte per cycle, set by the back stage while no result is held
// by rsp_stall; its multiply-by-ten is a shift and add.
// Reset (synchronous, active high) empties the pipeline and clears the
// message state and all published scores to zero.
// While rsp_stall is high the result holds steady; bytes keep flowing into the
// two-entry queue and front register, and req_stall rises once they are full.
`timescale 1ns / 1ps

module decimal_list_parser_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dlp_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dlp_pkg::SCORE_W-1:0] rsp_score_first,
   output logic [dlp_pkg::SCORE_W-1:0] rsp_score_second,
   output logic [dlp_pkg::SCORE_W-1:0] rsp_score_third,
   output logic [dlp_pkg::COUNT_W-1:0] rsp_new_count
);

   logic                   front_valid, front_stall;
   dlp_pkg::char_item_type front_item;
   logic                   back_valid, back_stall;
   dlp_pkg::char_item_type back_item;

   dlp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .cls_valid   (front_valid),
      .cls_stall   (front_stall),
      .cls_item    (front_item)
   );

   dlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_stall (front_stall),
      .wr_item  (front_item),
      .rd_valid (back_valid),
      .rd_stall (back_stall),
      .rd_item  (back_item)
   );

   dlp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cls_valid        (back_valid),
      .cls_stall        (back_stall),
      .cls_item         (back_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_score_first  (rsp_score_first),
      .rsp_score_second (rsp_score_second),
      .rsp_score_third  (rsp_score_third),
      .rsp_new_count    (rsp_new_count)
   );

endmodule

// File: verif/tb_decimal_list_parser_top.sv
// Self-checking testbench for the decimal list parser: directed messages, then random traffic.
`timescale 1ns / 1ps

module tb_decimal_list_parser_top;

   // One published score board as the block should report it
   typedef struct packed {
      logic [dlp_pkg::SCORE_W-1:0] first;
      logic [dlp_pkg::SCORE_W-1:0] second;
      logic [dlp_pkg::SCORE_W-1:0] third;
      logic [dlp_pkg::COUNT_W-1:0] new_count;
   } score_board_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   logic [dlp_pkg::BYTE_W-1:0]   req_rx_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   logic [dlp_pkg::SCORE_W-1:0]  rsp_score_first;
   logic [dlp_pkg::SCORE_W-1:0]  rsp_score_second;
   logic [dlp_pkg::SCORE_W-1:0]  rsp_score_third;
   logic [dlp_pkg::COUNT_W-1:0]  rsp_new_count;

   // Parser state mirrored by the testbench
   logic [dlp_pkg::CHAR_W-1:0]  msg_len;
   logic [dlp_pkg::SCORE_W-1:0] num_value;
   logic [dlp_pkg::DIGIT_W-1:0] num_digits;
   logic [dlp_pkg::STAGE_W-1:0] staged_n;
   logic [dlp_pkg::SCORE_W-1:0] staged_val [dlp_pkg::LIST_LENGTH];
   logic [dlp_pkg::SCORE_W-1:0] board      [dlp_pkg::LIST_LENGTH];

   score_board_type board_queue [$];

   int error_count = 0;
   int byte_total  = 0;
   int burst_left  = 0;
   int stall_left  = 0;
   int stall_mode  = 0;

   decimal_list_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_score_first  (rsp_score_first),
      .rsp_score_second (rsp_score_second),
      .rsp_score_third  (rsp_score_third),
      .rsp_new_count    (rsp_new_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_message();
      msg_len    = '0;
      num_value  = '0;
      num_digits = '0;
      staged_n   = '0;
   endfunction

   function automatic void commit_number();
      if (num_digits != 0) begin
         if (staged_n < dlp_pkg::LIST_LENGTH) begin
            staged_val[staged_n] = num_value;
            staged_n = staged_n + 1'b1;
         end
         num_value  = '0;
         num_digits = '0;
      end
   endfunction

   // Advance the mirrored state by one accepted byte; '^' queues a score board
   function automatic void parse_byte(input logic [dlp_pkg::BYTE_W-1:0] b);
      logic [dlp_pkg::PROD_W-1:0]  prod;
      logic [dlp_pkg::SCORE_W-1:0] ranks [dlp_pkg::OUT_RANKS];
      score_board_type             board_out;
      if (b == dlp_pkg::CH_TERM) begin
         commit_number();
         for (int i = 0; i < dlp_pkg::LIST_LENGTH; i++)
            if (i < staged_n) board[i] = staged_val[i];
         for (int r = 0; r < dlp_pkg::OUT_RANKS; r++)
            ranks[r] = (r < dlp_pkg::LIST_LENGTH) ? board[r] : '0;
         board_out.first     = ranks[0];
         board_out.second    = ranks[1];
         board_out.third     = ranks[2];
         board_out.new_count = dlp_pkg::COUNT_W'(staged_n);
         board_queue.push_back(board_out);
         clear_message();
      end else if (msg_len >= dlp_pkg::CHAR_LIMIT) begin
         // overlong message: drop it along with this byte
         clear_message();
      end else begin
         msg_len = msg_len + 1'b1;
         if (b >= dlp_pkg::CH_ZERO && b <= dlp_pkg::CH_NINE) begin
            if (num_digits >= dlp_pkg::DIGIT_FULL) begin
               num_value  = dlp_pkg::NUMBER_CEILING;
               num_digits = dlp_pkg::DIGIT_OVER;
            end else begin
               prod = {{(dlp_pkg::PROD_W-dlp_pkg::SCORE_W){1'b0}}, num_value}
                    * dlp_pkg::PROD_W'(10)
                    + dlp_pkg::PROD_W'(b - dlp_pkg::CH_ZERO);
               num_value  = (prod > dlp_pkg::PROD_W'(dlp_pkg::NUMBER_CEILING))
                          ? dlp_pkg::NUMBER_CEILING : prod[dlp_pkg::SCORE_W-1:0];
               num_digits = num_digits + 1'b1;
            end
         end else if (b == dlp_pkg::CH_SPACE || b == dlp_pkg::CH_COMMA ||
                      b == dlp_pkg::CH_LBRACK || b == dlp_pkg::CH_RBRACK) begin
            commit_number();
         end
      end
   endfunction

   // ---------------------------------------------------------------- sender

   // Drive one item and return at the edge that accepts it; idles between bursts
   task automatic send_byte(input logic [dlp_pkg::BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(13, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(b);
      burst_left--;
      byte_total++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
   endtask

   function automatic logic [dlp_pkg::BYTE_W-1:0] rand_sep();
      case ($urandom_range(0, 3))
         0:       return dlp_pkg::CH_SPACE;
         1:       return dlp_pkg::CH_COMMA;
         2:       return dlp_pkg::CH_LBRACK;
         default: return dlp_pkg::CH_RBRACK;
      endcase
   endfunction

   // Any byte the parser skips
   function automatic logic [dlp_pkg::BYTE_W-1:0] rand_junk();
      logic [dlp_pkg::BYTE_W-1:0] b;
      do begin
         b = dlp_pkg::BYTE_W'($urandom_range(0, 255));
      end while ((b >= dlp_pkg::CH_ZERO && b <= dlp_pkg::CH_NINE) ||
                 b == dlp_pkg::CH_SPACE || b == dlp_pkg::CH_COMMA ||
                 b == dlp_pkg::CH_LBRACK || b == dlp_pkg::CH_RBRACK ||
                 b == dlp_pkg::CH_TERM);
      return b;
   endfunction

   // ---------------------------------------------------------------- receiver

   // Stall pattern: changes mode every so often, including stretches with no stall
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 150);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 1) == 1);
         2:       rsp_stall <= ($urandom_range(0, 9) != 0);
         default: rsp_stall <= (stall_left % 3 == 0);
      endcase
   end

   function automatic void check_field(input string field,
                                       input logic [dlp_pkg::SCORE_W-1:0] want,
                                       input logic [dlp_pkg::SCORE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted result with the oldest expected board
   always @(posedge clock) begin
      score_board_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (board_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d count %0d",
                     $time, rsp_score_first, rsp_score_second, rsp_score_third,
                     rsp_new_count);
            error_count++;
         end else begin
            want = board_queue.pop_front();
            check_field("score_first",  want.first,  rsp_score_first);
            check_field("score_second", want.second, rsp_score_second);
            check_field("score_third",  want.third,  rsp_score_third);
            check_field("new_count", dlp_pkg::SCORE_W'(want.new_count),
                        dlp_pkg::SCORE_W'(rsp_new_count));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Full list with every separator, a short list, an empty message
   task automatic test_basic_lists();
      send_text("[12, 345,6]^");
      send_text("7^");
      send_text("^");
   endtask

   // Exact ceiling, saturation past nine digits, leading zeros
   task automatic test_long_numbers();
      send_text("999999999,1234567890 0009^");
      send_text("0000000000001^");
   endtask

   // Numbers beyond the list are dropped; other bytes are skipped
   task automatic test_extra_and_junk();
      send_text("1 2 3 4 5^");
      send_text("a1b^");
   endtask

   // 49 held bytes still parse; one more byte throws the message away
   task automatic test_message_length();
      repeat (dlp_pkg::CHAR_LIMIT - 1) send_byte("a");
      send_text("3^");
      repeat (dlp_pkg::CHAR_LIMIT) send_byte("x");
      send_text("7");
      send_text("8^");
   endtask

   // Mostly well-formed messages with random content, some overlong, some noise
   task automatic test_random_traffic(input int byte_budget);
      int stop_at;
      int kind;
      int count;
      int len;
      bit nines;
      stop_at = byte_total + byte_budget;
      while (byte_total < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            repeat ($urandom_range(1, 20))
               send_byte(dlp_pkg::BYTE_W'($urandom_range(0, 255)));
         end else if (kind < 14) begin
            repeat ($urandom_range(50, 70)) begin
               case ($urandom_range(0, 2))
                  0: send_byte(dlp_pkg::CH_ZERO + dlp_pkg::BYTE_W'($urandom_range(0, 9)));
                  1:       send_byte(rand_sep());
                  default: send_byte(rand_junk());
               endcase
            end
            send_byte(dlp_pkg::CH_ZERO + dlp_pkg::BYTE_W'($urandom_range(0, 9)));
            send_byte(dlp_pkg::CH_TERM);
         end else begin
            if ($urandom_range(0, 1)) send_byte(dlp_pkg::CH_LBRACK);
            count = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 5);
            for (int k = 0; k < count; k++) begin
               case ($urandom_range(0, 9))
                  7, 8:    len = dlp_pkg::DIGIT_LIMIT;
                  9:       len = $urandom_range(dlp_pkg::DIGIT_LIMIT + 1,
                                                dlp_pkg::DIGIT_LIMIT + 3);
                  default: len = $urandom_range(1, dlp_pkg::DIGIT_LIMIT);
               endcase
               nines = ($urandom_range(0, 3) == 0);
               if ($urandom_range(0, 7) == 0)
                  repeat ($urandom_range(1, 3)) send_byte(dlp_pkg::CH_ZERO);
               repeat (len) begin
                  if (nines) send_byte(dlp_pkg::CH_NINE);
                  else send_byte(dlp_pkg::CH_ZERO + dlp_pkg::BYTE_W'($urandom_range(0, 9)));
                  if ($urandom_range(0, 15) == 0) send_byte(rand_junk());
               end
               // the last number is sometimes left for the terminator to commit
               if (k < count - 1 || $urandom_range(0, 1))
                  repeat ($urandom_range(1, 2)) send_byte(rand_sep());
            end
            if ($urandom_range(0, 1)) send_byte(dlp_pkg::CH_RBRACK);
            send_byte(dlp_pkg::CH_TERM);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_message();
      for (int i = 0; i < dlp_pkg::LIST_LENGTH; i++) begin
         staged_val[i] = '0;
         board[i]      = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_lists();
      test_long_numbers();
      test_extra_and_junk();
      test_message_length();
      test_random_traffic(1530);

      req_valid <= 1'b0;
      while (board_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("decimal_list_parser_top test passed");
      end else begin
         $display("decimal_list_parser_top test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20ms;
      $display("decimal_list_parser_top test failed");
      $finish;
   end

endmodule
